/* hw/rtl/iprt_pkg.sv */
// Shared types, codes and helpers for the IPv4 prefix route table.
package iprt_pkg;

  localparam logic [5:0] FULL_LEN = 6'd32;
  localparam logic [4:0] COST_MAX = 5'd16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_NO_IF = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } state_t;

  // One table row as stored in the route memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [31:0] gateway;
    logic [3:0]  port;
    logic [4:0]  cost;
    logic        priv;
  } entry_t;

  // Search key of the item being worked on.
  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  len;
    logic [31:0] pfx;
  } key_t;

  // Outcome of one pass over the table.
  typedef struct packed {
    logic   best_found;
    entry_t best;
    logic   exact_found;
    logic   free_found;
  } scan_res_t;

  // Netmask for a length of 0..32.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    len_mask = ~(32'hFFFF_FFFF >> len);
  endfunction

endpackage

/* hw/rtl/iprt_if.sv */
// Request and response channel interfaces of the route table.
interface iprt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] address;
  logic [5:0]  prefix_len;
  logic [31:0] next_gateway;
  logic [3:0]  out_port;
  logic [4:0]  route_cost;
  logic        hide_flag;

  modport source (
    output valid, operation, address, prefix_len, next_gateway, out_port,
           route_cost, hide_flag,
    input  ready
  );
  modport sink (
    input  valid, operation, address, prefix_len, next_gateway, out_port,
           route_cost, hide_flag,
    output ready
  );
endinterface

interface iprt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_gateway;
  logic [3:0]  found_port;
  logic [4:0]  found_cost;
  logic        found_private;
  logic [5:0]  found_len;

  modport source (
    output valid, status, found_gateway, found_port, found_cost,
           found_private, found_len,
    input  ready
  );
  modport sink (
    input  valid, status, found_gateway, found_port, found_cost,
           found_private, found_len,
    output ready
  );
endinterface

/* hw/rtl/iprt_scan.sv */
// Match accumulator: folds one table row per cycle, while rd_pend is high, into the scan outcome.
module iprt_scan import iprt_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             rd_pend,
  input  logic [IDX_W-1:0] rd_idx,
  input  entry_t           rd_data,
  input  key_t             key,
  output scan_res_t        res,
  output logic [IDX_W-1:0] tgt_idx
);

  logic [IDX_W-1:0] exact_idx;
  logic [IDX_W-1:0] free_idx;
  logic             is_match;
  logic             is_better;
  logic             is_exact;

  always_comb begin
    is_match  = rd_data.valid &&
                ((key.addr & len_mask(rd_data.length)) == rd_data.prefix);
    // strictly longer wins, so the lowest slot keeps ties
    is_better = !res.best_found || (rd_data.length > res.best.length);
    is_exact  = rd_data.valid && (rd_data.length == key.len) &&
                (rd_data.prefix == key.pfx);
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.best_found  <= 1'b0;
      res.exact_found <= 1'b0;
      res.free_found  <= 1'b0;
    end else if (rd_pend) begin
      if (is_match && is_better) begin
        res.best_found <= 1'b1;
        res.best       <= rd_data;
      end
      if (is_exact && !res.exact_found) begin
        res.exact_found <= 1'b1;
        exact_idx       <= rd_idx;
      end
      if (!rd_data.valid && !res.free_found) begin
        res.free_found <= 1'b1;
        free_idx       <= rd_idx;
      end
    end
  end

  assign tgt_idx = res.exact_found ? exact_idx : free_idx;

endmodule

/* hw/rtl/ip_prefix_route_table.sv */
// Top level of the IPv4 longest-prefix-match route table with default route.
// Requests: one is accepted only while idle and answered after a scan of the
//   whole table through the single read port of the route memory, which is
//   scanned one row per cycle; the next is taken once the last is answered.
// Reset: a clearing pass marks every row invalid; requests are held off
//   until it ends. Default route resets to no interface.
module ip_prefix_route_table import iprt_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  iprt_req_if.sink    req,
  iprt_rsp_if.source  rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Route memory: one row per slot, one write and one registered read a cycle.
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;

  state_t state, state_next;

  logic [IDX_W-1:0] scan_cnt;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_pend;

  // Latched request, with length and metric already saturated.
  logic [1:0]  q_op;
  key_t        q_key;
  logic [31:0] q_gw;
  logic [3:0]  q_port;
  logic [4:0]  q_cost;
  logic        q_priv;

  // Default route.
  logic [31:0] dflt_gateway;
  logic [3:0]  dflt_port;
  logic [4:0]  dflt_cost;
  logic        dflt_private;

  scan_res_t        scan_res;
  logic [IDX_W-1:0] tgt_idx;

  logic        req_fire;
  logic        fin_go;
  logic [5:0]  in_len;
  logic [4:0]  in_cost;

  // Write port and the results of the finishing step.
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             dflt_set;
  logic             dflt_kill;
  logic [1:0]       res_status;
  logic [31:0]      res_gw;
  logic [3:0]       res_port;
  logic [4:0]       res_cost;
  logic             res_priv;
  logic [5:0]       res_len;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign fin_go    = (state == S_FINISH) && (!rsp.valid || rsp.ready);

  assign in_len  = (req.prefix_len > FULL_LEN) ? FULL_LEN : req.prefix_len;
  assign in_cost = (req.route_cost > COST_MAX) ? COST_MAX : req.route_cost;

  // ---------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (scan_cnt == LAST_IDX) state_next = S_IDLE;
      S_IDLE:   if (req_fire) state_next = S_SCAN;
      S_SCAN:   if (scan_cnt == LAST_IDX) state_next = S_LAST;
      S_LAST:   state_next = S_FINISH;
      S_FINISH: if (fin_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Row counter, shared by the clearing pass and the table scan.
  always_ff @(posedge clk) begin
    if (rst || req_fire) begin
      scan_cnt <= '0;
    end else if (state == S_CLEAR || state == S_SCAN) begin
      if (scan_cnt != LAST_IDX) scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // Read data is registered and lands in the cycle after the address; rd_pend tags it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= scan_cnt;
    rd_data <= mem[scan_cnt];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // ---------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req_fire) begin
      q_op       <= req.operation;
      q_key.addr <= req.address;
      q_key.len  <= in_len;
      q_key.pfx  <= req.address & len_mask(in_len);
      q_gw       <= req.next_gateway;
      q_port     <= req.out_port;
      q_cost     <= in_cost;
      q_priv     <= req.hide_flag;
    end
  end

  iprt_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (req_fire),
    .rd_pend (rd_pend),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .key     (q_key),
    .res     (scan_res),
    .tgt_idx (tgt_idx)
  );

  // ---------------------------------------------------------------------
  // Finishing step: response and write-back, decided after the full scan
  // ---------------------------------------------------------------------
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = tgt_idx;
    wr_data    = '0;
    dflt_set   = 1'b0;
    dflt_kill  = 1'b0;
    res_status = STAT_MISS;
    res_gw     = '0;
    res_port   = '0;
    res_cost   = '0;
    res_priv   = 1'b0;
    res_len    = '0;

    if (state == S_CLEAR) begin
      // clearing pass writes an invalid row everywhere
      wr_en   = 1'b1;
      wr_addr = scan_cnt;
    end else begin
      case (q_op)
        OP_LOOKUP: begin
          if (scan_res.best_found) begin
            res_status = STAT_OK;
            res_gw     = scan_res.best.gateway;
            res_port   = scan_res.best.port;
            res_cost   = scan_res.best.cost;
            res_priv   = scan_res.best.priv;
            res_len    = scan_res.best.length;
          end else if (dflt_port != '0) begin
            res_status = STAT_OK;
            res_gw     = dflt_gateway;
            res_port   = dflt_port;
            res_cost   = dflt_cost;
            res_priv   = dflt_private;
          end
        end
        OP_ADD: begin
          if (q_port == '0) begin
            res_status = STAT_NO_IF;
          end else if (q_key.len == '0) begin
            dflt_set   = fin_go;
            res_status = STAT_OK;
          end else if (scan_res.exact_found || scan_res.free_found) begin
            // update in place, else take the lowest free slot
            wr_en           = fin_go;
            wr_data.valid   = 1'b1;
            wr_data.prefix  = q_key.pfx;
            wr_data.length  = q_key.len;
            wr_data.gateway = q_gw;
            wr_data.port    = q_port;
            wr_data.cost    = q_cost;
            wr_data.priv    = q_priv;
            res_status      = STAT_OK;
          end else begin
            res_status = STAT_FULL;
          end
        end
        OP_DELETE: begin
          if (q_key.len == '0) begin
            dflt_kill  = fin_go;
            res_status = STAT_OK;
          end else if (scan_res.exact_found) begin
            wr_en      = fin_go;
            res_status = STAT_OK;
          end
        end
        default: res_status = STAT_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_gateway <= '0;
      dflt_port    <= '0;
      dflt_cost    <= COST_MAX;
      dflt_private <= 1'b0;
    end else if (dflt_set) begin
      dflt_gateway <= q_gw;
      dflt_port    <= q_port;
      dflt_cost    <= q_cost;
      dflt_private <= q_priv;
    end else if (dflt_kill) begin
      dflt_port <= '0;
    end
  end

  // Output register: holds a finished item while the next one is scanned.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fin_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp.status        <= res_status;
      rsp.found_gateway <= res_gw;
      rsp.found_port    <= res_port;
      rsp.found_cost    <= res_cost;
      rsp.found_private <= res_priv;
      rsp.found_len     <= res_len;
    end
  end

endmodule

/* tb/sv/tb_ip_prefix_route_table.sv */
// Self-checking testbench for the IPv4 longest-prefix route table.
module tb_ip_prefix_route_table import iprt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUTE_SLOTS  = 64;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 10;
  localparam int KEY_COUNT    = 128;   // pool of route keys used by random items
  localparam int BASE_COUNT   = 8;     // keys share a few bases so prefixes nest
  localparam int BLOCK_ITEMS  = 261;
  localparam int BLOCK_COUNT  = 7;
  localparam int HOLD_CYCLES  = 600;   // long reply back-pressure stretch
  localparam int SETTLE       = 80;    // longer than the scan of one request
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int REPORT_CAP   = 200;

  // Operation code 3 has no name in the package; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [31:0] gw;
    logic [3:0]  port;
    logic [4:0]  cost;
    logic        hide;
  } route_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] gw;
    logic [3:0]  port;
    logic [4:0]  cost;
    logic        priv;
    logic [5:0]  len;
  } route_rsp_t;

  // Shadow copy of the route table: predicts each reply on accept and checks
  // replies in order against the queue of replies still due.
  class route_table_shadow;
    bit        used  [ROUTE_SLOTS];
    bit [31:0] pfx   [ROUTE_SLOTS];
    bit [5:0]  plen  [ROUTE_SLOTS];
    bit [31:0] gw    [ROUTE_SLOTS];
    bit [3:0]  port  [ROUTE_SLOTS];
    bit [4:0]  cost  [ROUTE_SLOTS];
    bit        priv  [ROUTE_SLOTS];
    bit [31:0] dflt_gw;
    bit [3:0]  dflt_port;
    bit [4:0]  dflt_cost;
    bit        dflt_priv;
    route_rsp_t replies_due[$];
    int mismatches;
    int tally[4][4];   // [operation][status]

    function new();
      dflt_cost = COST_MAX;
    endfunction

    static function bit [31:0] netmask(int unsigned len);
      return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function int find_route(bit [31:0] p, bit [5:0] l);
      for (int i = 0; i < ROUTE_SLOTS; i++)
        if (used[i] && plen[i] == l && pfx[i] == p) return i;
      return -1;
    endfunction

    function route_rsp_t route_outcome(route_req_t r);
      route_rsp_t o;
      int slot;
      bit [5:0] l;
      bit [4:0] c;
      bit [31:0] p;
      o.status = STAT_MISS;
      o.gw = '0;
      o.port = '0;
      o.cost = '0;
      o.priv = 1'b0;
      o.len = '0;
      l = (r.len > FULL_LEN) ? FULL_LEN : r.len;
      c = (r.cost > COST_MAX) ? COST_MAX : r.cost;
      p = r.addr & netmask(l);
      case (r.op)
        OP_LOOKUP: begin
          slot = -1;
          for (int i = 0; i < ROUTE_SLOTS; i++)
            if (used[i] && (r.addr & netmask(plen[i])) == pfx[i] &&
                (slot < 0 || plen[i] > plen[slot])) slot = i;
          if (slot >= 0) begin
            o.status = STAT_OK;
            o.gw = gw[slot];
            o.port = port[slot];
            o.cost = cost[slot];
            o.priv = priv[slot];
            o.len = plen[slot];
          end else if (dflt_port != 0) begin
            o.status = STAT_OK;
            o.gw = dflt_gw;
            o.port = dflt_port;
            o.cost = dflt_cost;
            o.priv = dflt_priv;
          end
        end
        OP_ADD: begin
          if (r.port == 0) begin
            o.status = STAT_NO_IF;
          end else if (l == 0) begin
            dflt_gw = r.gw;
            dflt_port = r.port;
            dflt_cost = c;
            dflt_priv = r.hide;
            o.status = STAT_OK;
          end else begin
            slot = find_route(p, l);
            if (slot < 0)
              for (int i = 0; i < ROUTE_SLOTS; i++)
                if (!used[i]) begin
                  slot = i;
                  break;
                end
            if (slot < 0) begin
              o.status = STAT_FULL;
            end else begin
              used[slot] = 1'b1;
              pfx[slot] = p;
              plen[slot] = l;
              gw[slot] = r.gw;
              port[slot] = r.port;
              cost[slot] = c;
              priv[slot] = r.hide;
              o.status = STAT_OK;
            end
          end
        end
        OP_DELETE: begin
          if (l == 0) begin
            dflt_port = '0;
            o.status = STAT_OK;
          end else begin
            slot = find_route(p, l);
            if (slot >= 0) begin
              used[slot] = 1'b0;
              o.status = STAT_OK;
            end
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void accept_request(route_req_t r);
      route_rsp_t o;
      o = route_outcome(r);
      replies_due.push_back(o);
      tally[r.op][o.status]++;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected %0h, got %0h", what, want, got);
    endfunction

    function void compare_reply(route_rsp_t a);
      route_rsp_t e;
      if (replies_due.size() == 0) begin
        mismatches++;
        $error("reply item with no request outstanding");
        return;
      end
      e = replies_due.pop_front();
      if (a.status !== e.status) flag("status", e.status, a.status);
      if (a.gw !== e.gw) flag("found_gateway", e.gw, a.gw);
      if (a.port !== e.port) flag("found_port", e.port, a.port);
      if (a.cost !== e.cost) flag("found_cost", e.cost, a.cost);
      if (a.priv !== e.priv) flag("found_private", e.priv, a.priv);
      if (a.len !== e.len) flag("found_len", e.len, a.len);
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  iprt_req_if req_bus ();
  iprt_rsp_if rsp_bus ();

  ip_prefix_route_table #(.TABLE_ENTRIES(ROUTE_SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #(CLK_HALF) clk = ~clk;

  route_table_shadow shadow = new();

  bit [31:0] base_addr [BASE_COUNT];
  bit [31:0] key_addr  [KEY_COUNT];
  bit [5:0]  key_len   [KEY_COUNT];
  bit        hold_replies = 1'b0;   // sender asks the reply side for a long hold-off
  int        quiet_cycles = 0;

  // Known values on every block input from time zero.
  initial begin
    req_bus.valid = 1'b0;
    req_bus.operation = OP_LOOKUP;
    req_bus.address = '0;
    req_bus.prefix_len = '0;
    req_bus.next_gateway = '0;
    req_bus.out_port = '0;
    req_bus.route_cost = '0;
    req_bus.hide_flag = 1'b0;
    rsp_bus.ready = 1'b0;
  end

  function automatic route_req_t make_req(logic [1:0] op, logic [31:0] addr, logic [5:0] len,
                                          logic [31:0] gw, logic [3:0] port,
                                          logic [4:0] cost, logic hide);
    route_req_t r;
    r.op = op;
    r.addr = addr;
    r.len = len;
    r.gw = gw;
    r.port = port;
    r.cost = cost;
    r.hide = hide;
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, an occasional long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  // Random request built around the key pool so that adds collide, deletes
  // find their targets and lookups land inside stored (often nested) prefixes.
  // Fields a given operation ignores stay random to toggle every bit.
  function automatic route_req_t random_request(int add_pct, int del_pct);
    route_req_t r;
    int pick;
    int k;
    bit [31:0] m;
    r.op = OP_LOOKUP;
    r.addr = $urandom;
    r.len = 6'($urandom_range(0, 63));
    r.gw = $urandom;
    r.port = 4'($urandom_range(0, 15));
    r.cost = 5'($urandom_range(0, 31));
    r.hide = 1'($urandom_range(0, 1));
    k = $urandom_range(0, KEY_COUNT - 1);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.op = OP_UNUSED;
    end else if (pick < 3 + add_pct) begin
      r.op = OP_ADD;
      r.addr = key_addr[k];
      r.len = key_len[k];
      r.port = ($urandom_range(0, 11) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      if ($urandom_range(0, 9) == 0) r.gw = '0;   // direct route
      if ($urandom_range(0, 11) == 0) r.len = '0;
      else if ($urandom_range(0, 24) == 0) r.len = 6'($urandom_range(33, 63));
    end else if (pick < 3 + add_pct + del_pct) begin
      r.op = OP_DELETE;
      r.addr = key_addr[k];
      r.len = key_len[k];
      if ($urandom_range(0, 11) == 0) r.len = '0;
      else if ($urandom_range(0, 24) == 0) r.len = 6'($urandom_range(33, 63));
      else if ($urandom_range(0, 9) == 0) r.addr = $urandom;   // likely absent
    end else begin
      m = route_table_shadow::netmask(key_len[k]);
      case ($urandom_range(0, 3))
        0, 1: r.addr = (key_addr[k] & m) | ($urandom & ~m);
        2:    r.addr = base_addr[$urandom_range(0, BASE_COUNT - 1)];
        default: ;
      endcase
    end
    return r;
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // into the next item when no gap follows.
  task automatic send_request(route_req_t r, int gap);
    req_bus.valid <= 1'b1;
    req_bus.operation <= r.op;
    req_bus.address <= r.addr;
    req_bus.prefix_len <= r.len;
    req_bus.next_gateway <= r.gw;
    req_bus.out_port <= r.port;
    req_bus.route_cost <= r.cost;
    req_bus.hide_flag <= r.hide;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    shadow.accept_request(r);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted reply has come back.
  task automatic drain_replies();
    req_bus.valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  // Reply side pacing: open stretches, random short and long stalls, and a
  // long hold-off on request so that the block backs up into its input.
  initial begin
    int unsigned p;
    while (rst) @(posedge clk);
    forever begin
      if (hold_replies) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_replies = 1'b0;
      end else begin
        p = $urandom_range(0, 99);
        rsp_bus.ready <= 1'b1;
        if (p < 20) begin
          repeat ($urandom_range(100, 400)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 8)) @(posedge clk);
          rsp_bus.ready <= 1'b0;
          if (p < 90) repeat ($urandom_range(1, 4)) @(posedge clk);
          else repeat ($urandom_range(30, 150)) @(posedge clk);
        end
      end
    end
  end

  // Reply capture: values sampled at the edge, before the block updates them.
  always @(posedge clk) begin
    route_rsp_t a;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      a.status = status_t'(rsp_bus.status);
      a.gw = rsp_bus.found_gateway;
      a.port = rsp_bus.found_port;
      a.cost = rsp_bus.found_cost;
      a.priv = rsp_bus.found_private;
      a.len = rsp_bus.found_len;
      shadow.compare_reply(a);
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ip_prefix_route_table test failed");
      $finish;
    end
  end

  initial begin
    int add_pct;
    int del_pct;
    bit calm;
    int b;
    bit [31:0] m;

    // Key pool: a handful of bases, random lengths, junk in the host bits
    // so that the block's own masking is exercised on adds.
    foreach (base_addr[i]) base_addr[i] = $urandom;
    foreach (key_addr[k]) begin
      b = $urandom_range(0, BASE_COUNT - 1);
      key_len[k] = 6'($urandom_range(1, 32));
      m = route_table_shadow::netmask(key_len[k]);
      key_addr[k] = (base_addr[b] & m) | ($urandom & ~m);
    end

    // Reset once; the block then runs its clearing pass with ready low.
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Empty table, no default: miss.
    send_request(make_req(OP_LOOKUP, 32'h0A01_0203, 6'd24, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    // Default route without an interface is refused.
    send_request(make_req(OP_ADD, 32'h0, 6'd0, 32'h0102_0304, 4'd0, 5'd3, 1'b0), pick_gap());
    // Default route, all-ones fields, metric saturates.
    send_request(make_req(OP_ADD, 32'hDEAD_BEEF, 6'd0, 32'hFFFF_FFFF, 4'd15, 5'd31, 1'b1),
                 pick_gap());
    send_request(make_req(OP_LOOKUP, 32'h0102_0304, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    // Nested prefixes; host bits set in the prefixes on purpose.
    send_request(make_req(OP_ADD, 32'h0A12_3456, 6'd8, 32'h0, 4'd1, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_ADD, 32'h0A01_FFFF, 6'd16, 32'hC0A8_0001, 4'd2, 5'd16, 1'b1),
                 pick_gap());
    send_request(make_req(OP_ADD, 32'h0A01_0203, 6'd32, 32'h0A00_0001, 4'd3, 5'd17, 1'b0),
                 pick_gap());
    // Length above 32 behaves as a host route.
    send_request(make_req(OP_ADD, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 4'd15, 5'd31, 1'b1),
                 pick_gap());
    send_request(make_req(OP_ADD, 32'h8000_0000, 6'd1, 32'h0000_0001, 4'd4, 5'd5, 1'b0),
                 pick_gap());
    // Longest match wins.
    send_request(make_req(OP_LOOKUP, 32'h0A01_0203, 6'd63, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_LOOKUP, 32'h0A01_0909, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_LOOKUP, 32'h0AC8_0001, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_LOOKUP, 32'hC000_0000, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    // Update of an existing prefix in place.
    send_request(make_req(OP_ADD, 32'h0A00_0000, 6'd8, 32'h1234_5678, 4'd7, 5'd9, 1'b1),
                 pick_gap());
    send_request(make_req(OP_LOOKUP, 32'h0A05_0505, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    // Non-default add without an interface.
    send_request(make_req(OP_ADD, 32'h0B00_0000, 6'd8, 32'h0, 4'd0, 5'd1, 1'b0), pick_gap());
    // Delete, then delete of an absent entry.
    send_request(make_req(OP_DELETE, 32'h0A01_0000, 6'd16, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_LOOKUP, 32'h0A01_0909, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_DELETE, 32'h0A01_0000, 6'd16, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_DELETE, 32'hFFFF_FFFF, 6'd40, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    // Delete of the default clears only its interface.
    send_request(make_req(OP_DELETE, 32'h0, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    send_request(make_req(OP_LOOKUP, 32'h0100_0000, 6'd0, 32'h0, 4'd0, 5'd0, 1'b0), pick_gap());
    // Unused operation code.
    send_request(make_req(OP_UNUSED, $urandom, 6'($urandom), $urandom, 4'($urandom),
                          5'($urandom), 1'($urandom)), pick_gap());

    // Sender pause: everything in flight must come back first.
    drain_replies();

    // Random part in blocks that fill, churn and drain the table in turn;
    // fill blocks push it to full.
    for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
      case (blk % 3)
        0:       begin add_pct = 60; del_pct = 5;  end
        1:       begin add_pct = 30; del_pct = 30; end
        default: begin add_pct = 5;  del_pct = 55; end
      endcase
      calm = ($urandom_range(0, 2) == 0);
      // Reply side holds off while requests keep coming.
      if (blk == 2) hold_replies = 1'b1;
      for (int n = 0; n < BLOCK_ITEMS; n++)
        send_request(random_request(add_pct, del_pct), calm ? 0 : pick_gap());
      if (blk == 4) drain_replies();
    end

    drain_replies();
    repeat (SETTLE) @(posedge clk);

    $display("covered: lookups %0d routed / %0d missed; adds %0d stored, %0d no interface, %0d full",
             shadow.tally[OP_LOOKUP][STAT_OK], shadow.tally[OP_LOOKUP][STAT_MISS],
             shadow.tally[OP_ADD][STAT_OK], shadow.tally[OP_ADD][STAT_NO_IF],
             shadow.tally[OP_ADD][STAT_FULL]);
    $display("covered: deletes %0d removed / %0d absent; unused op %0d; mismatches %0d",
             shadow.tally[OP_DELETE][STAT_OK], shadow.tally[OP_DELETE][STAT_MISS],
             shadow.tally[OP_UNUSED][STAT_MISS], shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("ip_prefix_route_table test passed");
    end else begin
      $display("ip_prefix_route_table test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/iprt_pkg.sv
hw/rtl/iprt_if.sv
hw/rtl/iprt_scan.sv
hw/rtl/ip_prefix_route_table.sv
tb/sv/tb_ip_prefix_route_table.sv
